>>> rtl/mlpr_pkg.sv
// shared constants, types and layer tables for the mlp relu inference block
// no dependencies
package mlpr_pkg;

	localparam int IN_SIZE      = 14;
	localparam int HIDDEN_ONE   = 30;
	localparam int HIDDEN_TWO   = 30;
	localparam int HIDDEN_THREE = 30;
	localparam int OUT_SIZE     = 1;
	localparam int FRAC_BITS    = 16;

	localparam int WORD_W = 24;
	localparam int ADDR_W = 12;
	localparam int FIDX_W = 4;

	localparam int W1_BASE     = 0;
	localparam int W2_BASE     = W1_BASE + IN_SIZE * HIDDEN_ONE;
	localparam int W3_BASE     = W2_BASE + HIDDEN_ONE * HIDDEN_TWO;
	localparam int W4_BASE     = W3_BASE + HIDDEN_TWO * HIDDEN_THREE;
	localparam int B1_BASE     = W4_BASE + HIDDEN_THREE * OUT_SIZE;
	localparam int B2_BASE     = B1_BASE + HIDDEN_ONE;
	localparam int B3_BASE     = B2_BASE + HIDDEN_TWO;
	localparam int B4_BASE     = B3_BASE + HIDDEN_THREE;
	localparam int PARAM_DEPTH = B4_BASE + OUT_SIZE;

	localparam int ACT_DEPTH_12 = (HIDDEN_ONE > HIDDEN_TWO) ? HIDDEN_ONE : HIDDEN_TWO;
	localparam int ACT_DEPTH    = (ACT_DEPTH_12 > HIDDEN_THREE) ? ACT_DEPTH_12 : HIDDEN_THREE;
	localparam int MAX_DIM      = (ACT_DEPTH > IN_SIZE) ? ACT_DEPTH : IN_SIZE;

	localparam int ACC_W = 2 * WORD_W + 8;
	localparam int CNT_W = $clog2(MAX_DIM + 1);

	typedef logic [CNT_W-1:0]         cnt_t;
	typedef logic [ADDR_W-1:0]        addr_t;
	typedef logic signed [WORD_W-1:0] word_t;
	typedef logic signed [ACC_W-1:0]  acc_t;
	typedef logic [1:0]               layer_t;

	localparam layer_t LAST_LAYER = layer_t'(3);
	localparam logic   OP_PARAM   = 1'b0;
	localparam logic   OP_FEATURE = 1'b1;

	localparam word_t WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
	localparam word_t WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_BIAS,
		ST_MAC,
		ST_DRAIN,
		ST_FINAL,
		ST_PAD,
		ST_RESULT
	} seq_state_t;

	typedef struct packed {
		logic shift;
		logic load;
	} act_ctl_t;

	typedef struct packed {
		logic shift;
		logic inject;
	} acc_ctl_t;

	function automatic cnt_t layer_n_in(layer_t l);
		unique case (l)
			2'd0: layer_n_in = cnt_t'(IN_SIZE);
			2'd1: layer_n_in = cnt_t'(HIDDEN_ONE);
			2'd2: layer_n_in = cnt_t'(HIDDEN_TWO);
			default: layer_n_in = cnt_t'(HIDDEN_THREE);
		endcase
	endfunction

	function automatic cnt_t layer_n_out(layer_t l);
		unique case (l)
			2'd0: layer_n_out = cnt_t'(HIDDEN_ONE);
			2'd1: layer_n_out = cnt_t'(HIDDEN_TWO);
			2'd2: layer_n_out = cnt_t'(HIDDEN_THREE);
			default: layer_n_out = cnt_t'(OUT_SIZE);
		endcase
	endfunction

	function automatic addr_t layer_w_base(layer_t l);
		unique case (l)
			2'd0: layer_w_base = addr_t'(W1_BASE);
			2'd1: layer_w_base = addr_t'(W2_BASE);
			2'd2: layer_w_base = addr_t'(W3_BASE);
			default: layer_w_base = addr_t'(W4_BASE);
		endcase
	endfunction

	function automatic addr_t layer_b_base(layer_t l);
		unique case (l)
			2'd0: layer_b_base = addr_t'(B1_BASE);
			2'd1: layer_b_base = addr_t'(B2_BASE);
			2'd2: layer_b_base = addr_t'(B3_BASE);
			default: layer_b_base = addr_t'(B4_BASE);
		endcase
	endfunction

endpackage

>>> rtl/mlpr_act_cell.sv
// one activation cell of the input/activation chain
// depends on mlpr_pkg
module mlpr_act_cell (
	input  logic             clk,
	input  logic             arst_n,
	input  mlpr_pkg::act_ctl_t ctl,
	input  mlpr_pkg::word_t  load_val,
	input  mlpr_pkg::word_t  nxt,
	output mlpr_pkg::word_t  q
);
	import mlpr_pkg::*;

	word_t val_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			val_q <= '0;
		end else if (ctl.load) begin
			val_q <= load_val;
		end else if (ctl.shift) begin
			val_q <= nxt;
		end
	end

	assign q = val_q;

endmodule

>>> rtl/mlpr_acc_cell.sv
// one accumulator cell of the rotating neuron-sum chain
// depends on mlpr_pkg
module mlpr_acc_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  mlpr_pkg::acc_ctl_t ctl,
	input  mlpr_pkg::acc_t    inject_val,
	input  mlpr_pkg::acc_t    nxt,
	output mlpr_pkg::acc_t    q
);
	import mlpr_pkg::*;

	acc_t sum_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else if (ctl.shift) begin
			sum_q <= ctl.inject ? inject_val : nxt;
		end
	end

	assign q = sum_q;

endmodule

>>> rtl/mlp_relu_inference.sv
// top level: parameter memory, layer sequencer, mac pipeline and the two cell chains
// depends on mlpr_pkg, mlpr_act_cell, mlpr_acc_cell
module mlp_relu_inference (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic                         op,
	input  mlpr_pkg::addr_t              param_addr,
	input  logic [mlpr_pkg::FIDX_W-1:0]  feature_index,
	input  mlpr_pkg::word_t              word_value,
	input  logic                         last,
	output logic                         out_valid,
	input  logic                         out_stall,
	output mlpr_pkg::word_t              net_output,
	output logic                         saturated
);
	// Parameter loads and feature writes are taken while the input is not stalled.
	// A feature transaction with last set starts an inference, during which the
	// input is stalled. Each layer loads its biases, multiply-accumulates through
	// the single parameter memory read port, drains the mac pipeline, rounds and
	// saturates its n_out sums, and realigns the activation chain (not after the
	// output layer); the result is then handed over once the output side is free.
	// The result sits in an output register, so new transactions are taken while
	// it waits. Unwritten parameter words read back as unknown.
	import mlpr_pkg::*;

	seq_state_t state_q, state_d;
	layer_t     layer_q;
	cnt_t       j_q, k_q, pad_q;
	addr_t      addr_q;
	logic       sat_q;
	word_t      res_q;

	logic       out_valid_q;
	word_t      net_output_q;
	logic       saturated_q;

	logic       valid_s1, bias_s1, valid_s2;
	word_t      rd_s1, x_s1;
	acc_t       prod_s2;
	logic signed [2*WORD_W-1:0] mul;

	word_t      param_mem [PARAM_DEPTH];

	word_t      act_q [ACT_DEPTH];
	acc_t       acc_q [ACT_DEPTH];
	act_ctl_t   act_ctl [ACT_DEPTH];
	acc_ctl_t   acc_ctl [ACT_DEPTH];

	cnt_t       n_in, n_out;
	logic       j_last, k_last, in_acc, start, out_free, pipe_empty;
	logic       issue, act_shift, acc_shift;
	word_t      act_tail;
	acc_t       acc_inject;
	acc_t       rounded, shifted;
	word_t      fin_val, relu_val;
	logic       clip;

	assign n_in       = layer_n_in(layer_q);
	assign n_out      = layer_n_out(layer_q);
	assign j_last     = (j_q == n_out - cnt_t'(1));
	assign k_last     = (k_q == n_in - cnt_t'(1));
	assign in_stall   = (state_q != ST_IDLE);
	assign in_acc     = in_valid && !in_stall;
	assign start      = in_acc && (op == OP_FEATURE) && last;
	assign out_free   = !out_valid_q || !out_stall;
	assign pipe_empty = !valid_s1 && !valid_s2;

	// round half up, floor shift, then clip to the word range
	assign rounded = acc_q[0] + (acc_t'(1) <<< (FRAC_BITS - 1));
	assign shifted = rounded >>> FRAC_BITS;
	always_comb begin
		clip = 1'b0;
		fin_val = shifted[WORD_W-1:0];
		if (shifted > acc_t'(WORD_MAX)) begin
			clip = 1'b1;
			fin_val = WORD_MAX;
		end else if (shifted < acc_t'(WORD_MIN)) begin
			clip = 1'b1;
			fin_val = WORD_MIN;
		end
	end
	assign relu_val = fin_val[WORD_W-1] ? '0 : fin_val;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   if (start) state_d = ST_BIAS;
			ST_BIAS:   if (j_last) state_d = ST_MAC;
			ST_MAC:    if (j_last && k_last) state_d = ST_DRAIN;
			ST_DRAIN:  if (pipe_empty) state_d = ST_FINAL;
			ST_FINAL: begin
				if (j_last) begin
					if (layer_q == LAST_LAYER) state_d = ST_RESULT;
					else if (n_out < cnt_t'(ACT_DEPTH)) state_d = ST_PAD;
					else state_d = ST_BIAS;
				end
			end
			ST_PAD:    if (pad_q == cnt_t'(ACT_DEPTH - 1)) state_d = ST_BIAS;
			ST_RESULT: if (out_free) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// datapath controls
	always_comb begin
		issue      = 1'b0;
		act_shift  = 1'b0;
		act_tail   = '0;
		acc_shift  = valid_s2;
		acc_inject = acc_q[0] + prod_s2;
		unique case (state_q)
			ST_BIAS: issue = 1'b1;
			ST_MAC: begin
				issue = 1'b1;
				act_shift = j_last;
			end
			ST_FINAL: begin
				acc_shift  = 1'b1;
				acc_inject = '0;
				act_shift  = (layer_q != LAST_LAYER);
				act_tail   = relu_val;
			end
			ST_PAD: act_shift = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			layer_q <= '0;
			j_q     <= '0;
			k_q     <= '0;
			pad_q   <= '0;
			addr_q  <= '0;
			sat_q   <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						layer_q <= '0;
						j_q     <= '0;
						addr_q  <= layer_b_base('0);
					end
				end
				ST_BIAS: begin
					if (j_last) begin
						j_q    <= '0;
						k_q    <= '0;
						addr_q <= layer_w_base(layer_q);
					end else begin
						j_q    <= j_q + cnt_t'(1);
						addr_q <= addr_q + addr_t'(1);
					end
				end
				ST_MAC: begin
					addr_q <= addr_q + addr_t'(1);
					if (j_last) begin
						j_q <= '0;
						k_q <= k_q + cnt_t'(1);
					end else begin
						j_q <= j_q + cnt_t'(1);
					end
				end
				ST_DRAIN: j_q <= '0;
				ST_FINAL: begin
					sat_q <= sat_q | clip;
					pad_q <= n_out;
					j_q   <= j_q + cnt_t'(1);
					if (state_d == ST_BIAS) begin
						layer_q <= layer_q + layer_t'(1);
						addr_q  <= layer_b_base(layer_q + layer_t'(1));
						j_q     <= '0;
					end
				end
				ST_PAD: begin
					pad_q <= pad_q + cnt_t'(1);
					if (state_d == ST_BIAS) begin
						layer_q <= layer_q + layer_t'(1);
						addr_q  <= layer_b_base(layer_q + layer_t'(1));
						j_q     <= '0;
					end
				end
				ST_RESULT: if (out_free) sat_q <= 1'b0;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_FINAL && layer_q == LAST_LAYER) begin
			res_q <= fin_val;
		end
	end

	// parameter memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (in_acc && op == OP_PARAM && param_addr < addr_t'(PARAM_DEPTH)) begin
			param_mem[param_addr] <= word_value;
		end
	end

	always_ff @(posedge clk) begin
		rd_s1 <= param_mem[addr_q];
	end

	// mac pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= issue;
			valid_s2 <= valid_s1;
		end
	end

	assign mul = rd_s1 * x_s1;

	always_ff @(posedge clk) begin
		bias_s1 <= (state_q == ST_BIAS);
		x_s1    <= act_q[0];
		prod_s2 <= bias_s1 ? (acc_t'(rd_s1) <<< FRAC_BITS) : acc_t'(mul);
	end

	// cell chains
	for (genvar i = 0; i < ACT_DEPTH; i++) begin : g_cells
		word_t act_nxt;
		acc_t  acc_nxt;

		if (i == ACT_DEPTH - 1) begin : g_tail
			assign act_nxt = act_tail;
			assign acc_nxt = '0;
		end else begin : g_body
			assign act_nxt = act_q[i+1];
			assign acc_nxt = acc_q[i+1];
		end

		if (i < IN_SIZE) begin : g_feat
			assign act_ctl[i].load = in_acc && (op == OP_FEATURE) &&
				(feature_index == FIDX_W'(i));
		end else begin : g_nofeat
			assign act_ctl[i].load = 1'b0;
		end
		assign act_ctl[i].shift  = act_shift;
		assign acc_ctl[i].shift  = acc_shift;
		assign acc_ctl[i].inject = (cnt_t'(i) == n_out - cnt_t'(1));

		mlpr_act_cell u_act (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (act_ctl[i]),
			.load_val (word_value),
			.nxt      (act_nxt),
			.q        (act_q[i])
		);

		mlpr_acc_cell u_acc (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (acc_ctl[i]),
			.inject_val (acc_inject),
			.nxt        (acc_nxt),
			.q          (acc_q[i])
		);
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_RESULT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_RESULT && out_free) begin
			net_output_q <= res_q;
			saturated_q  <= sat_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign net_output = net_output_q;
	assign saturated  = saturated_q;

`ifndef SYNTHESIS
	a_final_drained: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FINAL |-> pipe_empty)
		else $error("finalize with mac pipeline busy");
	a_idle_acc_clear: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> acc_q[0] == '0)
		else $error("accumulator chain not cleared after inference");
	a_result_shown: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RESULT && out_free) |=> out_valid_q && state_q == ST_IDLE)
		else $error("result not loaded into output register");
	a_idle_sat_clear: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> !sat_q && pipe_empty)
		else $error("saturation flag or pipeline left over in idle");
`endif

endmodule
